// ===== src/search_transposition_table_macros.svh =====
// Assertion macros shared by the search transposition table RTL.
// No dependencies; included by the modules that carry assertions.
`ifndef SEARCH_TRANSPOSITION_TABLE_MACROS_SVH
`define SEARCH_TRANSPOSITION_TABLE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define STT_ASSERT_HOLDS(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define STT_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
  lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/stt_pkg.sv =====
// Shared types and constants for the search transposition table.
// No dependencies; used by stt_ctrl, stt_dp and the top level.
package stt_pkg;

  // Table geometry (TABLE_ENTRIES must be a power of two)
  localparam int TABLE_ENTRIES = 1024;
  localparam int MAX_LINE      = 32;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int CNT_W         = $clog2(MAX_LINE + 1);
  localparam int LS_AW         = $clog2(TABLE_ENTRIES * MAX_LINE);

  // Item kinds
  localparam logic [2:0] KIND_RECORD = 3'd0;
  localparam logic [2:0] KIND_PV     = 3'd1;
  localparam logic [2:0] KIND_PROBE  = 3'd2;
  localparam logic [2:0] KIND_LINE   = 3'd3;
  localparam logic [2:0] KIND_CLEAR  = 3'd4;

  // Bound types
  localparam logic [1:0] BOUND_EXACT = 2'd0;
  localparam logic [1:0] BOUND_LOWER = 2'd1;
  localparam logic [1:0] BOUND_UPPER = 2'd2;

  // Result kinds
  localparam logic RES_PROBE = 1'b0;
  localparam logic RES_LINE  = 1'b1;

  // Configuration register indexes
  localparam int         CFG_IDX_W = 1;
  localparam logic [0:0] CFG_INF   = 1'b0;
  localparam logic [0:0] CFG_WIN   = 1'b1;

  // Output register source
  typedef enum logic [1:0] {
    OUT_PROBE,
    OUT_NOLINE,
    OUT_MOVE
  } out_sel_t;

  // Controller to datapath
  typedef struct packed {
    logic     latch_in;
    logic     cls_load;
    logic     cls_probe;
    logic     adj_load;
    logic     rec_write;
    logic     pv_write;
    logic     fill_clear;
    logic     clr_step;
    logic     pos_inc;
    logic     out_load;
    out_sel_t out_sel;
  } stt_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_open;
    logic out_free;
    logic rl_ok;
    logic pos_last;
    logic clr_last;
  } stt_stat_t;

endpackage

// ===== src/stt_dp.sv =====
// Datapath of the search transposition table: config, entry and line memories,
// mate-score shift, probe bound rules and output register. Uses stt_pkg.
module stt_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  stt_pkg::stt_cmd_t             cmd,
  output stt_pkg::stt_stat_t            stat,
  input  logic                          cfg_valid,
  input  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic [63:0]                   in_key,
  input  logic [7:0]                    in_depth,
  input  logic [1:0]                    in_entry_type,
  input  logic signed [31:0]            in_score,
  input  logic signed [31:0]            in_alpha,
  input  logic signed [31:0]            in_beta,
  input  logic [7:0]                    in_ply,
  input  logic [7:0]                    in_pv_length,
  input  logic [15:0]                   in_move,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic                          out_hit,
  output logic signed [31:0]            out_result_score,
  output logic [1:0]                    out_found_type,
  output logic [15:0]                   out_line_move,
  output logic                          out_line_found,
  output logic                          out_last
);

  localparam int IDX_W = stt_pkg::IDX_W;
  localparam int CNT_W = stt_pkg::CNT_W;
  localparam int LS_AW = stt_pkg::LS_AW;
  localparam logic signed [32:0] SAT_MAX = 33'sd2147483647;
  localparam logic signed [32:0] SAT_MIN = -33'sd2147483648;

  typedef struct packed {
    logic [63:0]        key;
    logic [7:0]         depth;
    logic [1:0]         bound;
    logic signed [31:0] score;
  } entry_t;

  function automatic logic signed [31:0] sat32(input logic signed [32:0] v);
    if (v > SAT_MAX) begin
      return SAT_MAX[31:0];
    end else if (v < SAT_MIN) begin
      return SAT_MIN[31:0];
    end
    return v[31:0];
  endfunction

  // Configuration and derived mate thresholds
  logic [30:0]        inf_r;
  logic [15:0]        win_r;
  logic signed [32:0] hi_thr_r, lo_thr_r, hi_thr_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inf_r <= 31'd1000000;
      win_r <= 16'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        stt_pkg::CFG_INF: inf_r <= cfg_data[30:0];
        stt_pkg::CFG_WIN: win_r <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  assign hi_thr_nxt = $signed({2'b00, inf_r}) - $signed({17'd0, win_r});

  always_ff @(posedge clk) begin
    hi_thr_r <= hi_thr_nxt;
    lo_thr_r <= -hi_thr_nxt;
  end

  // Transaction latch
  logic [63:0]        key_r;
  logic [7:0]         depth_r, ply_r, pvlen_r;
  logic [1:0]         etype_r;
  logic signed [31:0] score_r, alpha_r, beta_r;
  logic [15:0]        move_r;
  logic [IDX_W-1:0]   idx;

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      key_r   <= in_key;
      depth_r <= in_depth;
      etype_r <= in_entry_type;
      score_r <= in_score;
      alpha_r <= in_alpha;
      beta_r  <= in_beta;
      ply_r   <= in_ply;
      pvlen_r <= in_pv_length;
      move_r  <= in_move;
    end
  end

  assign idx = key_r[IDX_W-1:0];

  // Line fill tracking, read position and clear sweep counter
  logic [IDX_W-1:0] fill_slot_r, clr_cnt_r;
  logic [CNT_W-1:0] fill_cnt_r, fill_tgt_r, fill_tgt_nxt, pos_r;

  always_comb begin
    fill_tgt_nxt = '0;
    if (etype_r == stt_pkg::BOUND_EXACT && pvlen_r != 8'd0) begin
      if (pvlen_r > 8'(stt_pkg::MAX_LINE)) begin
        fill_tgt_nxt = CNT_W'(stt_pkg::MAX_LINE);
      end else begin
        fill_tgt_nxt = pvlen_r[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_slot_r <= '0;
      fill_cnt_r  <= '0;
      fill_tgt_r  <= '0;
      clr_cnt_r   <= '0;
      pos_r       <= '0;
    end else begin
      if (cmd.rec_write) begin
        fill_slot_r <= idx;
        fill_cnt_r  <= '0;
        fill_tgt_r  <= fill_tgt_nxt;
      end else if (cmd.fill_clear) begin
        fill_cnt_r <= '0;
        fill_tgt_r <= '0;
      end else if (cmd.pv_write) begin
        fill_cnt_r <= fill_cnt_r + CNT_W'(1);
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= stat.clr_last ? '0 : clr_cnt_r + IDX_W'(1);
      end
      if (cmd.latch_in) begin
        pos_r <= '0;
      end else if (cmd.pos_inc) begin
        pos_r <= pos_r + CNT_W'(1);
      end
    end
  end

  // Mate-score classification and shift
  logic signed [31:0] cls_src, work_r, adj_r, adj_nxt;
  logic signed [32:0] cls_ext;
  logic signed [8:0]  ply_pos, ply_neg, delta_r, delta_nxt;
  logic               is_win, is_loss;

  entry_t             meta_q_r;

  assign cls_src = cmd.cls_probe ? meta_q_r.score : score_r;
  assign cls_ext = $signed({cls_src[31], cls_src});
  assign is_win  = cls_ext > hi_thr_r;
  assign is_loss = cls_ext < lo_thr_r;
  assign ply_pos = $signed({1'b0, ply_r});
  assign ply_neg = -ply_pos;

  always_comb begin
    delta_nxt = '0;
    if (is_win) begin
      delta_nxt = cmd.cls_probe ? ply_pos : ply_neg;
    end else if (is_loss) begin
      delta_nxt = cmd.cls_probe ? ply_neg : ply_pos;
    end
  end

  assign adj_nxt = sat32($signed({work_r[31], work_r}) +
                         $signed({{24{delta_r[8]}}, delta_r}));

  // Probe key/depth check result
  logic       pass_r;
  logic [1:0] bound_r;
  logic       valid_q_r;

  always_ff @(posedge clk) begin
    if (cmd.cls_load) begin
      work_r  <= cls_src;
      delta_r <= delta_nxt;
      pass_r  <= valid_q_r && (meta_q_r.key == key_r) && (meta_q_r.depth >= depth_r);
      bound_r <= meta_q_r.bound;
    end
    if (cmd.adj_load) begin
      adj_r <= adj_nxt;
    end
  end

  // Entry memories: a registered read at the slot each cycle; writes go to the slot, the fill slot or the sweep entry
  entry_t           meta_mem  [stt_pkg::TABLE_ENTRIES];
  logic             valid_mem [stt_pkg::TABLE_ENTRIES];
  logic [CNT_W-1:0] len_mem   [stt_pkg::TABLE_ENTRIES];
  logic [CNT_W-1:0] len_q_r;
  entry_t           entry_wr;

  assign entry_wr = '{key: key_r, depth: depth_r, bound: etype_r, score: adj_nxt};

  always_ff @(posedge clk) begin
    if (cmd.rec_write) begin
      meta_mem[idx] <= entry_wr;
    end
    meta_q_r <= meta_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      valid_mem[clr_cnt_r] <= 1'b0;
    end else if (cmd.rec_write) begin
      valid_mem[idx] <= 1'b1;
    end
    valid_q_r <= valid_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.rec_write) begin
      len_mem[idx] <= '0;
    end else if (cmd.pv_write) begin
      len_mem[fill_slot_r] <= fill_cnt_r + CNT_W'(1);
    end
    len_q_r <= len_mem[idx];
  end

  // Principal line memory, MAX_LINE moves per slot
  logic [15:0]      line_mem [stt_pkg::TABLE_ENTRIES * stt_pkg::MAX_LINE];
  logic [15:0]      line_q_r;
  logic [LS_AW-1:0] line_wr_addr, line_rd_addr;

  assign line_wr_addr = LS_AW'(fill_slot_r) * LS_AW'(stt_pkg::MAX_LINE) + LS_AW'(fill_cnt_r);
  assign line_rd_addr = LS_AW'(idx) * LS_AW'(stt_pkg::MAX_LINE) + LS_AW'(pos_r);

  always_ff @(posedge clk) begin
    if (cmd.pv_write) begin
      line_mem[line_wr_addr] <= move_r;
    end
    line_q_r <= line_mem[line_rd_addr];
  end

  // Status
  logic [CNT_W-1:0] line_n;
  logic             out_valid_r;

  assign line_n = (len_q_r > CNT_W'(stt_pkg::MAX_LINE)) ? CNT_W'(stt_pkg::MAX_LINE) : len_q_r;

  assign stat.fill_open = fill_cnt_r < fill_tgt_r;
  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.rl_ok     = valid_q_r && (meta_q_r.bound == stt_pkg::BOUND_EXACT) &&
                          (line_n != '0);
  assign stat.pos_last  = (pos_r + CNT_W'(1)) == line_n;
  assign stat.clr_last  = clr_cnt_r == IDX_W'(stt_pkg::TABLE_ENTRIES - 1);

  // Output payload selection
  logic               kind_nxt, hit_nxt, found_nxt, last_nxt;
  logic signed [31:0] rscore_nxt;
  logic [1:0]         ftype_nxt;
  logic [15:0]        move_nxt;

  always_comb begin
    kind_nxt   = stt_pkg::RES_PROBE;
    hit_nxt    = 1'b0;
    rscore_nxt = '0;
    ftype_nxt  = '0;
    move_nxt   = '0;
    found_nxt  = 1'b0;
    last_nxt   = 1'b1;
    case (cmd.out_sel)
      stt_pkg::OUT_PROBE: begin
        if (pass_r) begin
          ftype_nxt = bound_r;
          case (bound_r)
            stt_pkg::BOUND_EXACT: begin
              hit_nxt    = 1'b1;
              rscore_nxt = adj_r;
            end
            stt_pkg::BOUND_LOWER: begin
              if (adj_r <= alpha_r) begin
                hit_nxt    = 1'b1;
                rscore_nxt = alpha_r;
              end
            end
            stt_pkg::BOUND_UPPER: begin
              if (adj_r >= beta_r) begin
                hit_nxt    = 1'b1;
                rscore_nxt = beta_r;
              end
            end
            default: ;
          endcase
        end
      end
      stt_pkg::OUT_NOLINE: begin
        kind_nxt = stt_pkg::RES_LINE;
      end
      stt_pkg::OUT_MOVE: begin
        kind_nxt  = stt_pkg::RES_LINE;
        move_nxt  = line_q_r;
        found_nxt = 1'b1;
        last_nxt  = stat.pos_last;
      end
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_result_kind  <= kind_nxt;
      out_hit          <= hit_nxt;
      out_result_score <= rscore_nxt;
      out_found_type   <= ftype_nxt;
      out_line_move    <= move_nxt;
      out_line_found   <= found_nxt;
      out_last         <= last_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

// ===== src/stt_ctrl.sv =====
// Controller of the search transposition table: sequences each transaction
// and the clear sweep. Uses stt_pkg and the shared assertion macros.
`include "search_transposition_table_macros.svh"

module stt_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [2:0]         in_kind,
  output logic               in_stall,
  input  stt_pkg::stt_stat_t stat,
  output stt_pkg::stt_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_CLR,
    S_IDLE,
    S_REC_CLS,
    S_REC_WR,
    S_PV_WR,
    S_PR_RD,
    S_PR_CLS,
    S_PR_ADJ,
    S_PR_OUT,
    S_RL_RD,
    S_RL_CHK,
    S_RL_OUT,
    S_RL_WAIT
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        cmd.clr_step   = 1'b1;
        cmd.fill_clear = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch_in = 1'b1;
          case (in_kind)
            stt_pkg::KIND_RECORD: state_nxt = S_REC_CLS;
            stt_pkg::KIND_PV:     state_nxt = S_PV_WR;
            stt_pkg::KIND_PROBE:  state_nxt = S_PR_RD;
            stt_pkg::KIND_LINE:   state_nxt = S_RL_RD;
            stt_pkg::KIND_CLEAR:  state_nxt = S_CLR;
            default:              state_nxt = S_IDLE;
          endcase
        end
      end
      S_REC_CLS: begin
        cmd.cls_load = 1'b1;
        state_nxt    = S_REC_WR;
      end
      S_REC_WR: begin
        cmd.rec_write = 1'b1;
        state_nxt     = S_IDLE;
      end
      S_PV_WR: begin
        cmd.pv_write = stat.fill_open;
        state_nxt    = S_IDLE;
      end
      S_PR_RD: begin
        state_nxt = S_PR_CLS;
      end
      S_PR_CLS: begin
        cmd.cls_load  = 1'b1;
        cmd.cls_probe = 1'b1;
        state_nxt     = S_PR_ADJ;
      end
      S_PR_ADJ: begin
        cmd.adj_load = 1'b1;
        state_nxt    = S_PR_OUT;
      end
      S_PR_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = stt_pkg::OUT_PROBE;
          state_nxt    = S_IDLE;
        end
      end
      S_RL_RD: begin
        state_nxt = S_RL_CHK;
      end
      S_RL_CHK: begin
        if (stat.rl_ok) begin
          state_nxt = S_RL_OUT;
        end else if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = stt_pkg::OUT_NOLINE;
          state_nxt    = S_IDLE;
        end
      end
      S_RL_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = stt_pkg::OUT_MOVE;
          if (stat.pos_last) begin
            state_nxt = S_IDLE;
          end else begin
            cmd.pos_inc = 1'b1;
            state_nxt   = S_RL_WAIT;
          end
        end
      end
      S_RL_WAIT: begin
        state_nxt = S_RL_OUT;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register; reset starts the valid-bit sweep
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // Checks
  `STT_ASSERT_HOLDS(a_out_free, clk, rst_n, cmd.out_load, stat.out_free, "output overwritten")
  `STT_ASSERT_HOLDS(a_pv_open, clk, rst_n, cmd.pv_write, stat.fill_open, "move past line end")
  `STT_ASSERT_HOLDS(a_rec_order, clk, rst_n, cmd.rec_write, $past(state_r) == S_REC_CLS, "record write without shift")
  `STT_ASSERT_NEXT(a_line_end, clk, rst_n, cmd.out_load && cmd.out_sel == stt_pkg::OUT_MOVE && stat.pos_last, state_r == S_IDLE, "line run not closed")

endmodule

// ===== src/search_transposition_table.sv =====
// Probe: entry read, mate-score classification and shift, output register. Read line: entry
// check, then one move at a time (line memory read then output register). Record: score
// shift, then entry write; pv move: one write to the open line; unused kind: dropped. One
// transaction is in work at a time; the output register holds a result while the next
// transaction is accepted. Clear, and reset (synchronous, active low), sweep the valid memory
// one entry per cycle with in_stall high. Config registers reset to 1000000 and 256.
module search_transposition_table (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [2:0]                    in_kind,
  input  logic [63:0]                   in_key,
  input  logic [7:0]                    in_depth,
  input  logic [1:0]                    in_entry_type,
  input  logic signed [31:0]            in_score,
  input  logic signed [31:0]            in_alpha,
  input  logic signed [31:0]            in_beta,
  input  logic [7:0]                    in_ply,
  input  logic [7:0]                    in_pv_length,
  input  logic [15:0]                   in_move,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_result_kind,
  output logic                          out_hit,
  output logic signed [31:0]            out_result_score,
  output logic [1:0]                    out_found_type,
  output logic [15:0]                   out_line_move,
  output logic                          out_line_found,
  output logic                          out_last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stt_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  stt_pkg::stt_cmd_t  cmd;
  stt_pkg::stt_stat_t stat;

  // Register writes are always taken
  assign cfg_ready = 1'b1;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  stt_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid & cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_key           (in_key),
    .in_depth         (in_depth),
    .in_entry_type    (in_entry_type),
    .in_score         (in_score),
    .in_alpha         (in_alpha),
    .in_beta          (in_beta),
    .in_ply           (in_ply),
    .in_pv_length     (in_pv_length),
    .in_move          (in_move),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_result_kind  (out_result_kind),
    .out_hit          (out_hit),
    .out_result_score (out_result_score),
    .out_found_type   (out_found_type),
    .out_line_move    (out_line_move),
    .out_line_found   (out_line_found),
    .out_last         (out_last)
  );

endmodule
